// ===== design/hcba_pkg.sv =====
package hcba_pkg;

    localparam int unsigned SEC_W    = 6;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned BRIGHT_W = 16;
    localparam int unsigned BTN_W    = 7;
    localparam int unsigned CODE_W   = 3;

    localparam logic [SEC_W-1:0]    SEC_LAST    = SEC_W'(59);
    localparam logic [MIN_W-1:0]    MIN_LAST    = MIN_W'(59);
    localparam logic [HOUR_W-1:0]   HOUR_LAST   = HOUR_W'(23);
    localparam logic [BRIGHT_W-1:0] BRIGHT_STEP = BRIGHT_W'(40);
    localparam logic [BRIGHT_W-1:0] PERIOD_RST  = BRIGHT_W'(400);
    localparam int unsigned         LED_DIV     = 5;

    typedef enum logic [CODE_W-1:0] {
        ADJ_NONE        = 3'd0,
        ADJ_BRIGHT_DOWN = 3'd1,
        ADJ_BRIGHT_UP   = 3'd2,
        ADJ_HOUR_DOWN   = 3'd3,
        ADJ_HOUR_UP     = 3'd4,
        ADJ_MIN_DOWN    = 3'd5,
        ADJ_MIN_UP      = 3'd6,
        ADJ_SEC_RESET   = 3'd7
    } t_adjust;

    typedef enum logic {
        FUNC_TICK   = 1'b0,
        FUNC_SAMPLE = 1'b1
    } t_func;

    typedef struct packed {
        logic             func;
        logic [BTN_W-1:0] buttons;
    } t_in_word;

    typedef struct packed {
        logic [SEC_W-1:0]    seconds;
        logic [MIN_W-1:0]    minutes;
        logic [HOUR_W-1:0]   hours;
        logic [BRIGHT_W-1:0] brightness;
        logic [CODE_W-1:0]   pending_code;
        logic                led_five_seconds;
        logic                led_minute;
    } t_out_word;

endpackage

// ===== design/hcba_in_if.sv =====
interface hcba_in_if;
    import hcba_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [BTN_W-1:0] buttons;

    modport source (output valid, output func, output buttons, input ready);
    modport sink   (input valid, input func, input buttons, output ready);
endinterface

// ===== design/hcba_out_if.sv =====
interface hcba_out_if;
    import hcba_pkg::*;

    logic                valid;
    logic                ready;
    logic [SEC_W-1:0]    seconds;
    logic [MIN_W-1:0]    minutes;
    logic [HOUR_W-1:0]   hours;
    logic [BRIGHT_W-1:0] brightness;
    logic [CODE_W-1:0]   pending_code;
    logic                led_five_seconds;
    logic                led_minute;

    modport source (
        output valid, output seconds, output minutes, output hours, output brightness,
        output pending_code, output led_five_seconds, output led_minute, input ready
    );
    modport sink (
        input valid, input seconds, input minutes, input hours, input brightness,
        input pending_code, input led_five_seconds, input led_minute, output ready
    );
endinterface

// ===== design/hcba_in_reg.sv =====
module hcba_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hcba_in_if.sink           i_in,
    input  logic              i_advance,
    output logic              o_valid,
    output hcba_pkg::t_in_word o_word
);
    import hcba_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     w_ready;

    // take a new word when empty or when the held word moves on this cycle
    assign w_ready    = !r_valid || i_advance;
    assign i_in.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_in.valid) begin
            r_word.func    <= i_in.func;
            r_word.buttons <= i_in.buttons;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

// ===== design/hcba_core.sv =====
module hcba_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [hcba_pkg::BRIGHT_W-1:0] i_cfg_wr_data,
    input  logic                          i_fire,
    input  hcba_pkg::t_in_word            i_word,
    output hcba_pkg::t_out_word           o_result
);
    import hcba_pkg::*;

    logic [BRIGHT_W-1:0] r_period;
    logic [SEC_W-1:0]    r_sec;
    logic [MIN_W-1:0]    r_min;
    logic [HOUR_W-1:0]   r_hour;
    logic [BRIGHT_W-1:0] r_bright;
    t_adjust             r_pending;
    logic                r_led_five;
    logic                r_led_min;

    logic [SEC_W-1:0]    n_sec;
    logic [MIN_W-1:0]    n_min;
    logic [HOUR_W-1:0]   n_hour;
    logic [BRIGHT_W-1:0] n_bright;
    t_adjust             n_pending;
    logic                n_led_five;
    logic                n_led_min;

    function automatic logic is_mult5(input logic [SEC_W-1:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k * LED_DIV <= int'(SEC_LAST); k++) begin
            if (v == SEC_W'(k * LED_DIV)) hit = 1'b1;
        end
        return hit;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
        end else if (i_cfg_wr_en) begin
            r_period <= i_cfg_wr_data;
        end
    end

    always_comb begin
        logic [SEC_W-1:0]    adj_sec;
        logic [MIN_W-1:0]    adj_min;
        logic [HOUR_W-1:0]   adj_hour;
        logic [BRIGHT_W:0]   up_sum;
        logic [BRIGHT_W-1:0] up_sat;

        adj_sec    = r_sec;
        adj_min    = r_min;
        adj_hour   = r_hour;
        n_sec      = r_sec;
        n_min      = r_min;
        n_hour     = r_hour;
        n_bright   = r_bright;
        n_pending  = r_pending;
        n_led_five = r_led_five;
        n_led_min  = r_led_min;
        up_sum     = {1'b0, r_bright} + {1'b0, BRIGHT_STEP};
        up_sat     = up_sum[BRIGHT_W] ? '1 : up_sum[BRIGHT_W-1:0];

        if (i_word.func == FUNC_TICK) begin
            // apply the waiting adjustment before the seconds advance
            unique case (r_pending)
                ADJ_BRIGHT_DOWN: n_bright = (r_bright >= BRIGHT_STEP)
                                            ? r_bright - BRIGHT_STEP : '0;
                ADJ_BRIGHT_UP:   n_bright = (up_sat >= r_period) ? r_period : up_sat;
                ADJ_HOUR_DOWN:   adj_hour = (r_hour == '0) ? HOUR_LAST : r_hour - 1'b1;
                ADJ_HOUR_UP:     adj_hour = (r_hour >= HOUR_LAST) ? '0 : r_hour + 1'b1;
                ADJ_MIN_DOWN:    adj_min  = (r_min == '0) ? MIN_LAST : r_min - 1'b1;
                ADJ_MIN_UP:      adj_min  = (r_min >= MIN_LAST) ? '0 : r_min + 1'b1;
                ADJ_SEC_RESET:   adj_sec  = '0;
                default:         ;
            endcase

            n_pending = ADJ_NONE;
            n_min     = adj_min;
            n_hour    = adj_hour;
            n_led_min = 1'b0;
            if (adj_sec >= SEC_LAST) begin
                n_sec     = '0;
                n_led_min = 1'b1;
                if (adj_min >= MIN_LAST) begin
                    n_min  = '0;
                    n_hour = (adj_hour >= HOUR_LAST) ? '0 : adj_hour + 1'b1;
                end else begin
                    n_min = adj_min + 1'b1;
                end
            end else begin
                n_sec = adj_sec + 1'b1;
            end
            n_led_five = is_mult5(n_sec);
        end else if (r_pending == ADJ_NONE) begin
            // lowest pressed button wins
            for (int b = BTN_W - 1; b >= 0; b--) begin
                if (i_word.buttons[b]) n_pending = t_adjust'(CODE_W'(b + 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec      <= '0;
            r_min      <= '0;
            r_hour     <= '0;
            r_bright   <= '0;
            r_pending  <= ADJ_NONE;
            r_led_five <= 1'b0;
            r_led_min  <= 1'b0;
        end else if (i_fire) begin
            r_sec      <= n_sec;
            r_min      <= n_min;
            r_hour     <= n_hour;
            r_bright   <= n_bright;
            r_pending  <= n_pending;
            r_led_five <= n_led_five;
            r_led_min  <= n_led_min;
        end
    end

    always_comb begin
        o_result.seconds          = n_sec;
        o_result.minutes          = n_min;
        o_result.hours            = n_hour;
        o_result.brightness       = n_bright;
        o_result.pending_code     = n_pending;
        o_result.led_five_seconds = n_led_five;
        o_result.led_minute       = n_led_min;
    end
endmodule

// ===== design/hcba_out_reg.sv =====
module hcba_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hcba_pkg::t_out_word i_result,
    output logic                o_advance,
    hcba_out_if.source          o_out
);
    import hcba_pkg::*;

    logic      r_valid;
    t_out_word r_result;

    // free when empty or when the held word is taken this cycle
    assign o_advance = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.seconds          = r_result.seconds;
    assign o_out.minutes          = r_result.minutes;
    assign o_out.hours            = r_result.hours;
    assign o_out.brightness       = r_result.brightness;
    assign o_out.pending_code     = r_result.pending_code;
    assign o_out.led_five_seconds = r_result.led_five_seconds;
    assign o_out.led_minute       = r_result.led_minute;
endmodule

// ===== design/hms_clock_with_button_adjust_unit.sv =====
// Channel   | Dir | Handshake      | Word
// ----------+-----+----------------+-------------------------------------------------
// i_in      | in  | valid / ready  | func, buttons
// o_out     | out | valid / ready  | seconds, minutes, hours, brightness,
//           |     |                | pending_code, led_five_seconds, led_minute
// i_cfg_*   | in  | write enable   | pwm_period (16 bit)
//
// One word per cycle sustained while the output is not stalled.
// Input register, combinational update logic on the clock state, then the result register.
// Synchronous active-low reset clears the time, brightness, pending code and LED flags,
// and sets the period to 400.
// A stalled output holds its word; the input register takes one more word only while it is empty.
module hms_clock_with_button_adjust_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hcba_in_if.sink                       i_in,
    hcba_out_if.source                    o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [hcba_pkg::BRIGHT_W-1:0] i_cfg_wr_data
);
    import hcba_pkg::*;

    logic      w_in_valid;
    t_in_word  w_in_word;
    logic      w_advance;
    t_out_word w_result;

    hcba_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_word    (w_in_word)
    );

    hcba_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (w_in_valid && w_advance),
        .i_word        (w_in_word),
        .o_result      (w_result)
    );

    hcba_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_in_valid),
        .i_result  (w_result),
        .o_advance (w_advance),
        .o_out     (o_out)
    );
endmodule
